// File: src/utcb_pkg.sv
package utcb_pkg;

   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 64;

   localparam logic [7:0]  RST_COLS_IN_USE     = 8'd80;
   localparam logic [6:0]  RST_ROWS_IN_USE     = 7'd25;
   localparam logic [15:0] RST_CLEAR_ATTRIBUTE = 16'd7;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [1:0] CSR_COLS_IN_USE     = 2'd0;
   localparam logic [1:0] CSR_ROWS_IN_USE     = 2'd1;
   localparam logic [1:0] CSR_CLEAR_ATTRIBUTE = 2'd2;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   typedef struct packed {
      logic [7:0]  b3;
      logic [7:0]  b2;
      logic [7:0]  b1;
      logic [7:0]  b0;
      logic [2:0]  count;
      logic [1:0]  width;
      logic [15:0] attr;
   } cell_type;

   typedef enum logic [2:0] {
      CMD_SKIP,
      CMD_WRITE,
      CMD_WRITE_WIDE,
      CMD_READ,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [6:0]   row;
      logic [7:0]   col;
      cell_type     entry;
      logic [1:0]   written_width;
      logic [7:0]   lim_cols;
      logic [6:0]   lim_rows;
   } cmd_type;

   typedef struct packed {
      logic [1:0] written_width;
      logic       in_range;
      cell_type   entry;
   } rsp_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_WIDE,
      BK_READ,
      BK_CLEAR
   } back_state_type;

   function automatic cell_type space_cell(input logic [15:0] attr);
      cell_type c;
      c.b0    = SPACE_CHAR;
      c.b1    = 8'd0;
      c.b2    = 8'd0;
      c.b3    = 8'd0;
      c.count = 3'd1;
      c.width = 2'd1;
      c.attr  = attr;
      return c;
   endfunction

   function automatic logic [20:0] decode_cp(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] n);
      logic [20:0] cp;
      unique case (n)
         3'd1:    cp = {13'd0, b0};
         3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
         3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
         3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
         default: cp = 21'd0;
      endcase
      return cp;
   endfunction

   function automatic logic [1:0] cp_width(input logic [20:0] cp);
      logic wide;
      wide = (cp >= 21'hAC00 && cp <= 21'hD7A3) ||
             (cp >= 21'h1100 && cp <= 21'h11FF) ||
             (cp >= 21'h3130 && cp <= 21'h318F) ||
             (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
             (cp >= 21'h3400 && cp <= 21'h4DBF) ||
             (cp >= 21'hF900 && cp <= 21'hFAFF);
      return wide ? 2'd2 : 2'd1;
   endfunction

endpackage

// File: src/utf8_text_cell_buffer.sv
// Character-cell text buffer of MAX_ROWS x MAX_COLS cells held in one memory (one cell
// written and one cell read per cycle, registered read). After reset a clearing pass writes
// every cell to a space with attribute 7, during which req_ready stays low; csr writes
// are taken as usual. A front stage decodes UTF-8, sets the display width and checks the
// cell address, then hands the access to the back end through a two-entry queue. In the
// back end a narrow write, a rejected access, an opcode 3 or a clear of an empty area is
// done in the idle state, a read or a wide write passes on through its own second state,
// and a clear sweeps the active area, one memory write per cell. Each request yields one
// response beat from an output register; the back end takes the next command only when
// that register is empty or being read, while the queue still accepts requests until full.
module utf8_text_cell_buffer import utcb_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_col,
   input  logic [6:0]  req_row,
   input  logic [7:0]  req_byte0,
   input  logic [7:0]  req_byte1,
   input  logic [7:0]  req_byte2,
   input  logic [7:0]  req_byte3,
   input  logic [2:0]  req_byte_count,
   input  logic [15:0] req_attribute,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_written_width,
   output logic        rsp_in_range,
   output logic [7:0]  rsp_cell_byte0,
   output logic [7:0]  rsp_cell_byte1,
   output logic [7:0]  rsp_cell_byte2,
   output logic [7:0]  rsp_cell_byte3,
   output logic [2:0]  rsp_cell_count,
   output logic [1:0]  rsp_cell_width,
   output logic [15:0] rsp_cell_attribute
);

   back_status_type back_status;
   logic            push_valid;
   logic            push_ready;
   cmd_type         push_data;
   logic            pop_valid;
   logic            pop_ready;
   cmd_type         pop_data;
   rsp_type         rsp_data;

   utcb_front #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_byte0      (req_byte0),
      .req_byte1      (req_byte1),
      .req_byte2      (req_byte2),
      .req_byte3      (req_byte3),
      .req_byte_count (req_byte_count),
      .req_attribute  (req_attribute),
      .back_status    (back_status),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   utcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   utcb_back #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   assign rsp_written_width  = rsp_data.written_width;
   assign rsp_in_range       = rsp_data.in_range;
   assign rsp_cell_byte0     = rsp_data.entry.b0;
   assign rsp_cell_byte1     = rsp_data.entry.b1;
   assign rsp_cell_byte2     = rsp_data.entry.b2;
   assign rsp_cell_byte3     = rsp_data.entry.b3;
   assign rsp_cell_count     = rsp_data.entry.count;
   assign rsp_cell_width     = rsp_data.entry.width;
   assign rsp_cell_attribute = rsp_data.entry.attr;

   a_init_after_reset: assert property (@(posedge clock) reset |=> back_status.init_busy)
      else $error("clearing pass did not start after reset");

   a_no_req_in_init: assert property (@(posedge clock) disable iff (reset)
      back_status.init_busy |-> !req_ready)
      else $error("request taken during clearing pass");

   a_write_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_written_width != 2'd0 |-> !rsp_in_range && rsp_cell_count == 3'd0)
      else $error("write response carries cell data");

   a_push_into_full: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |-> !req_ready)
      else $error("request taken while queue full");

endmodule

// File: src/utcb_front.sv
module utcb_front import utcb_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_opcode,
   input  logic [7:0]      req_col,
   input  logic [6:0]      req_row,
   input  logic [7:0]      req_byte0,
   input  logic [7:0]      req_byte1,
   input  logic [7:0]      req_byte2,
   input  logic [7:0]      req_byte3,
   input  logic [2:0]      req_byte_count,
   input  logic [15:0]     req_attribute,
   input  back_status_type back_status,
   output logic            push_valid,
   input  logic            push_ready,
   output cmd_type         push_data
);

   logic [7:0]  cols_ff;
   logic [6:0]  rows_ff;
   logic [15:0] clr_attr_ff;

   logic [7:0]  eff_cols;
   logic [6:0]  eff_rows;
   logic [20:0] cp;
   logic [1:0]  w;
   logic        in_area;
   logic        fits;
   cell_type    wcell;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff     <= RST_COLS_IN_USE;
         rows_ff     <= RST_ROWS_IN_USE;
         clr_attr_ff <= RST_CLEAR_ATTRIBUTE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLS_IN_USE:     cols_ff     <= csr_wdata[7:0];
            CSR_ROWS_IN_USE:     rows_ff     <= csr_wdata[6:0];
            CSR_CLEAR_ATTRIBUTE: clr_attr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_cols = (9'(cols_ff) > 9'(MAX_COLS)) ? 8'(MAX_COLS) : cols_ff;
      eff_rows = (8'(rows_ff) > 8'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_ff;
      cp       = decode_cp(req_byte0, req_byte1, req_byte2, req_byte3, req_byte_count);
      w        = cp_width(cp);
      in_area  = (req_row < eff_rows) && (req_col < eff_cols);
      fits     = (9'(req_col) + 9'(w)) <= 9'(eff_cols);

      wcell.b0    = (req_byte_count > 3'd0) ? req_byte0 : 8'd0;
      wcell.b1    = (req_byte_count > 3'd1) ? req_byte1 : 8'd0;
      wcell.b2    = (req_byte_count > 3'd2) ? req_byte2 : 8'd0;
      wcell.b3    = (req_byte_count > 3'd3) ? req_byte3 : 8'd0;
      wcell.count = req_byte_count;
      wcell.width = w;
      wcell.attr  = req_attribute;

      push_data.row           = req_row;
      push_data.col           = req_col;
      push_data.entry         = wcell;
      push_data.written_width = 2'd0;
      push_data.lim_cols      = eff_cols;
      push_data.lim_rows      = eff_rows;
      push_data.kind          = CMD_SKIP;
      unique case (req_opcode)
         OP_WRITE: begin
            if (in_area && fits) begin
               push_data.kind          = (w == 2'd2) ? CMD_WRITE_WIDE : CMD_WRITE;
               push_data.written_width = w;
            end
         end
         OP_READ: begin
            if (in_area) begin
               push_data.kind = CMD_READ;
            end
         end
         OP_CLEAR: begin
            push_data.kind  = CMD_CLEAR;
            push_data.entry = space_cell(clr_attr_ff);
         end
         OP_NOP: ;
         default: ;
      endcase
   end

   assign push_valid = req_valid && !back_status.init_busy;
   assign req_ready  = push_ready && !back_status.init_busy;

endmodule

// File: src/utcb_queue.sv
module utcb_queue import utcb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: src/utcb_back.sv
module utcb_back import utcb_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  cmd_type         pop_data,
   output back_status_type back_status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);

   function automatic logic [AW-1:0] cell_addr(input logic [6:0] r, input logic [7:0] c);
      return AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
   endfunction

   cell_type       mem [DEPTH];
   cell_type       rdata_ff;

   back_state_type state_ff, state_in;
   cmd_type        cur_ff;
   logic [AW-1:0]  init_ff, init_in;
   logic [6:0]     r_ff, r_in;
   logic [7:0]     c_ff, c_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic           out_free;
   logic           take;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   cell_type       mem_wdata;
   logic           rsp_load;
   rsp_type        rsp_in;
   logic           clear_empty;
   logic           clear_last;
   logic           init_last;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign take        = pop_valid && pop_ready;
   assign clear_empty = (pop_data.lim_rows == 7'd0) || (pop_data.lim_cols == 8'd0);
   assign clear_last  = (c_ff == cur_ff.lim_cols - 8'd1) && (r_ff == cur_ff.lim_rows - 7'd1);
   assign init_last   = (init_ff == AW'(DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_INIT:  if (init_last) state_in = BK_IDLE;
         BK_IDLE: begin
            if (take) begin
               unique case (pop_data.kind)
                  CMD_WRITE_WIDE: state_in = BK_WIDE;
                  CMD_READ:       state_in = BK_READ;
                  CMD_CLEAR:      state_in = clear_empty ? BK_IDLE : BK_CLEAR;
                  default:        state_in = BK_IDLE;
               endcase
            end
         end
         BK_WIDE:  state_in = BK_IDLE;
         BK_READ:  state_in = BK_IDLE;
         BK_CLEAR: if (clear_last) state_in = BK_IDLE;
         default:  state_in = BK_INIT;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = cell_addr(pop_data.row, pop_data.col);
      mem_wdata = pop_data.entry;
      rsp_load  = 1'b0;
      rsp_in    = '0;
      init_in   = init_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      unique case (state_ff)
         BK_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = init_ff;
            mem_wdata = space_cell(RST_CLEAR_ATTRIBUTE);
            init_in   = init_ff + AW'(1);
         end
         BK_IDLE: begin
            pop_ready = out_free;
            r_in      = 7'd0;
            c_in      = 8'd0;
            if (take) begin
               unique case (pop_data.kind)
                  CMD_WRITE: begin
                     mem_we               = 1'b1;
                     rsp_load             = 1'b1;
                     rsp_in.written_width = pop_data.written_width;
                  end
                  CMD_WRITE_WIDE: mem_we = 1'b1;
                  CMD_CLEAR:      rsp_load = clear_empty;
                  CMD_READ: ;
                  default:        rsp_load = 1'b1;
               endcase
            end
         end
         BK_WIDE: begin
            mem_we               = 1'b1;
            mem_waddr            = cell_addr(cur_ff.row, cur_ff.col + 8'd1);
            mem_wdata            = '0;
            mem_wdata.attr       = cur_ff.entry.attr;
            rsp_load             = 1'b1;
            rsp_in.written_width = cur_ff.written_width;
         end
         BK_READ: begin
            rsp_load        = 1'b1;
            rsp_in.in_range = 1'b1;
            rsp_in.entry    = rdata_ff;
         end
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(r_ff, c_ff);
            mem_wdata = cur_ff.entry;
            rsp_load  = clear_last;
            if (c_ff == cur_ff.lim_cols - 8'd1) begin
               c_in = 8'd0;
               r_in = r_ff + 7'd1;
            end else begin
               c_in = c_ff + 8'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      c_ff <= c_in;
      if (take)     cur_ff <= pop_data;
      if (rsp_load) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[cell_addr(pop_data.row, pop_data.col)];
   end

   assign back_status.init_busy = (state_ff == BK_INIT);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data              = rsp_ff;

endmodule

// File: tb/sv/cell_buffer_check_pkg.sv
package cell_buffer_check_pkg;
   import utcb_pkg::*;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  col;
      logic [6:0]  row;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [2:0]  count;
      logic [15:0] attr;
   } access_type;

   class cell_access_checker;
      cell_type    cells [DEF_MAX_COLS*DEF_MAX_ROWS];
      logic [7:0]  cols_reg;
      logic [6:0]  rows_reg;
      logic [15:0] clear_attr;
      rsp_type     expected_rsp [$];
      int          errors;

      function new();
         cols_reg   = RST_COLS_IN_USE;
         rows_reg   = RST_ROWS_IN_USE;
         clear_attr = RST_CLEAR_ATTRIBUTE;
         errors     = 0;
         for (int i = 0; i < DEF_MAX_COLS*DEF_MAX_ROWS; i++) begin
            cells[i] = blank_cell(RST_CLEAR_ATTRIBUTE);
         end
      endfunction

      function cell_type blank_cell(logic [15:0] attr);
         cell_type c;
         c       = '0;
         c.b0    = SPACE_CHAR;
         c.count = 3'd1;
         c.width = 2'd1;
         c.attr  = attr;
         return c;
      endfunction

      function int area_cols();
         return (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_reg);
      endfunction

      function int area_rows();
         return (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_reg);
      endfunction

      function void set_register(logic [1:0] index, logic [15:0] value);
         case (index)
            CSR_COLS_IN_USE:     cols_reg = value[7:0];
            CSR_ROWS_IN_USE:     rows_reg = value[6:0];
            CSR_CLEAR_ATTRIBUTE: clear_attr = value;
            default: ;
         endcase
      endfunction

      function logic [20:0] code_point(access_type a);
         case (a.count)
            3'd1:    return {13'd0, a.b0};
            3'd2:    return {10'd0, a.b0[4:0], a.b1[5:0]};
            3'd3:    return {5'd0, a.b0[3:0], a.b1[5:0], a.b2[5:0]};
            3'd4:    return {a.b0[2:0], a.b1[5:0], a.b2[5:0], a.b3[5:0]};
            default: return 21'd0;
         endcase
      endfunction

      function logic [1:0] glyph_width(logic [20:0] cp);
         if ((cp >= 21'h0AC00 && cp <= 21'h0D7A3) || (cp >= 21'h01100 && cp <= 21'h011FF) ||
             (cp >= 21'h03130 && cp <= 21'h0318F) || (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
             (cp >= 21'h03400 && cp <= 21'h04DBF) || (cp >= 21'h0F900 && cp <= 21'h0FAFF)) begin
            return 2'd2;
         end
         return 2'd1;
      endfunction

      function void note_access(access_type a);
         rsp_type    rsp_exp;
         cell_type   c;
         int         cols;
         int         rows;
         int         idx;
         logic [1:0] w;
         rsp_exp = '0;
         cols    = area_cols();
         rows    = area_rows();
         idx     = int'(a.row) * DEF_MAX_COLS + int'(a.col);
         case (a.opcode)
            OP_WRITE: begin
               if (int'(a.row) < rows && int'(a.col) < cols) begin
                  w = glyph_width(code_point(a));
                  if (int'(a.col) + int'(w) <= cols) begin
                     c.b0    = (a.count > 3'd0) ? a.b0 : 8'd0;
                     c.b1    = (a.count > 3'd1) ? a.b1 : 8'd0;
                     c.b2    = (a.count > 3'd2) ? a.b2 : 8'd0;
                     c.b3    = (a.count > 3'd3) ? a.b3 : 8'd0;
                     c.count = a.count;
                     c.width = w;
                     c.attr  = a.attr;
                     cells[idx] = c;
                     if (w == 2'd2) begin
                        c      = '0;
                        c.attr = a.attr;
                        cells[idx + 1] = c;
                     end
                     rsp_exp.written_width = w;
                  end
               end
            end
            OP_READ: begin
               if (int'(a.row) < rows && int'(a.col) < cols) begin
                  rsp_exp.in_range = 1'b1;
                  rsp_exp.entry    = cells[idx];
               end
            end
            OP_CLEAR: begin
               for (int r = 0; r < rows; r++) begin
                  for (int k = 0; k < cols; k++) begin
                     cells[r * DEF_MAX_COLS + k] = blank_cell(clear_attr);
                  end
               end
            end
            default: ;
         endcase
         expected_rsp.push_back(rsp_exp);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $display("%0t: response beat with none pending, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("written_width", want.written_width, got.written_width);
         compare_field("in_range", want.in_range, got.in_range);
         compare_field("cell_byte0", want.entry.b0, got.entry.b0);
         compare_field("cell_byte1", want.entry.b1, got.entry.b1);
         compare_field("cell_byte2", want.entry.b2, got.entry.b2);
         compare_field("cell_byte3", want.entry.b3, got.entry.b3);
         compare_field("cell_count", want.entry.count, got.entry.count);
         compare_field("cell_width", want.entry.width, got.entry.width);
         compare_field("cell_attribute", want.entry.attr, got.entry.attr);
      endfunction
   endclass

endpackage

// File: tb/sv/utf8_text_cell_buffer_tb.sv
module utf8_text_cell_buffer_tb;
   import utcb_pkg::*;
   import cell_buffer_check_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [7:0]  req_col;
   logic [6:0]  req_row;
   logic [7:0]  req_byte0;
   logic [7:0]  req_byte1;
   logic [7:0]  req_byte2;
   logic [7:0]  req_byte3;
   logic [2:0]  req_byte_count;
   logic [15:0] req_attribute;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_written_width;
   logic        rsp_in_range;
   logic [7:0]  rsp_cell_byte0;
   logic [7:0]  rsp_cell_byte1;
   logic [7:0]  rsp_cell_byte2;
   logic [7:0]  rsp_cell_byte3;
   logic [2:0]  rsp_cell_count;
   logic [1:0]  rsp_cell_width;
   logic [15:0] rsp_cell_attribute;

   cell_access_checker sb;
   int          burst_left;
   bit          cleared_since_cfg;
   logic [7:0]  cur_cols;
   logic [6:0]  cur_rows;
   logic [7:0]  ncols;
   logic [6:0]  nrows;
   logic [15:0] nattr;
   int          span_c;
   int          span_r;
   int          clear_permille;
   int          rsp_mode;
   int          rsp_mode_left;
   rsp_type     got;

   utf8_text_cell_buffer dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_col            (req_col),
      .req_row            (req_row),
      .req_byte0          (req_byte0),
      .req_byte1          (req_byte1),
      .req_byte2          (req_byte2),
      .req_byte3          (req_byte3),
      .req_byte_count     (req_byte_count),
      .req_attribute      (req_attribute),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_written_width  (rsp_written_width),
      .rsp_in_range       (rsp_in_range),
      .rsp_cell_byte0     (rsp_cell_byte0),
      .rsp_cell_byte1     (rsp_cell_byte1),
      .rsp_cell_byte2     (rsp_cell_byte2),
      .rsp_cell_byte3     (rsp_cell_byte3),
      .rsp_cell_count     (rsp_cell_count),
      .rsp_cell_width     (rsp_cell_width),
      .rsp_cell_attribute (rsp_cell_attribute)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   function automatic access_type make_access(logic [1:0] op, logic [7:0] col, logic [6:0] row,
                                              logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                              logic [7:0] b3, logic [2:0] count,
                                              logic [15:0] attr);
      access_type a;
      a.opcode = op;
      a.col    = col;
      a.row    = row;
      a.b0     = b0;
      a.b1     = b1;
      a.b2     = b2;
      a.b3     = b3;
      a.count  = count;
      a.attr   = attr;
      return a;
   endfunction

   // mostly a small window near the origin, plus edges and anything the field allows
   function automatic int pick_coord(int span, int top);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0 || span == 0) return $urandom_range(0, top);
      if (sel == 1) return span - 1;
      if (sel == 2) return (span > 1) ? span - 2 : 0;
      if (sel == 3) return span;
      return $urandom_range(0, ((span < 24) ? span : 24) - 1);
   endfunction

   function automatic access_type random_access(int cols, int rows, int permille);
      access_type  a;
      int          sel;
      int          kind;
      bit          encode;
      bit          four;
      logic [20:0] cp;
      logic [20:0] lo;
      logic [20:0] hi;
      sel     = $urandom_range(0, 999);
      a.col   = 8'(pick_coord(cols, 255));
      a.row   = 7'(pick_coord(rows, 127));
      a.b0    = 8'($urandom);
      a.b1    = 8'($urandom);
      a.b2    = 8'($urandom);
      a.b3    = 8'($urandom);
      a.count = 3'($urandom_range(0, 7));
      a.attr  = 16'($urandom);
      encode  = 1'b0;
      four    = 1'b0;
      cp      = 21'd0;
      if (sel < permille) begin
         a.opcode = OP_CLEAR;
      end else if (sel < permille + 40) begin
         a.opcode = OP_NOP;
      end else if (sel < 500) begin
         a.opcode = OP_READ;
      end else begin
         a.opcode = OP_WRITE;
         kind = $urandom_range(0, 7);
         case (kind)
            0: begin
               a.count = 3'd1;
               a.b0    = {1'b0, a.b0[6:0]};
            end
            1: a.count = 3'd1;
            2: begin
               a.count = 3'd2;
               a.b0    = {3'b110, a.b0[4:0]};
               a.b1    = {2'b10, a.b1[5:0]};
            end
            3: begin
               case ($urandom_range(0, 5))
                  0: begin lo = 21'h0AC00; hi = 21'h0D7A3; end
                  1: begin lo = 21'h01100; hi = 21'h011FF; end
                  2: begin lo = 21'h03130; hi = 21'h0318F; end
                  3: begin lo = 21'h04E00; hi = 21'h09FFF; end
                  4: begin lo = 21'h03400; hi = 21'h04DBF; end
                  default: begin lo = 21'h0F900; hi = 21'h0FAFF; end
               endcase
               case ($urandom_range(0, 4))
                  0: cp = lo - 21'd1;
                  1: cp = lo;
                  2: cp = hi;
                  3: cp = hi + 21'd1;
                  default: cp = lo + 21'($urandom_range(0, int'(hi - lo)));
               endcase
               encode = 1'b1;
               four   = ($urandom_range(0, 3) == 0);
            end
            4: begin
               cp     = 21'($urandom_range(0, 16'hFFFF));
               encode = 1'b1;
            end
            5: begin
               cp     = 21'($urandom);
               encode = 1'b1;
               four   = 1'b1;
            end
            6: a.count = ($urandom_range(0, 1) == 1) ? 3'd0 : 3'($urandom_range(5, 7));
            default: ;
         endcase
         if (encode && four) begin
            a.count = 3'd4;
            a.b0    = {5'b11110, cp[20:18]};
            a.b1    = {2'b10, cp[17:12]};
            a.b2    = {2'b10, cp[11:6]};
            a.b3    = {2'b10, cp[5:0]};
         end else if (encode) begin
            a.count = 3'd3;
            a.b0    = {4'hE, cp[15:12]};
            a.b1    = {2'b10, cp[11:6]};
            a.b2    = {2'b10, cp[5:0]};
         end
      end
      return a;
   endfunction

   task automatic send_access(input access_type a);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 64) : $urandom_range(1, 12);
      end
      req_opcode     = a.opcode;
      req_col        = a.col;
      req_row        = a.row;
      req_byte0      = a.b0;
      req_byte1      = a.b1;
      req_byte2      = a.b2;
      req_byte3      = a.b3;
      req_byte_count = a.count;
      req_attribute  = a.attr;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_access(a);
      if (a.opcode == OP_CLEAR) cleared_since_cfg = 1'b1;
      burst_left--;
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
   endtask

   task automatic write_config(logic [7:0] cols, logic [6:0] rows, logic [15:0] attr);
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      // wait longer if a clear was sent since the last configuration
      repeat (cleared_since_cfg ? DEF_MAX_COLS*DEF_MAX_ROWS + 32 : 16) @(posedge clock);
      cleared_since_cfg = 1'b0;
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_COLS_IN_USE;
      csr_wdata = {8'd0, cols};
      sb.set_register(CSR_COLS_IN_USE, {8'd0, cols});
      @(negedge clock);
      csr_index = CSR_ROWS_IN_USE;
      csr_wdata = {9'd0, rows};
      sb.set_register(CSR_ROWS_IN_USE, {9'd0, rows});
      @(negedge clock);
      csr_index = CSR_CLEAR_ATTRIBUTE;
      csr_wdata = attr;
      sb.set_register(CSR_CLEAR_ATTRIBUTE, attr);
      @(negedge clock);
      csr_we   = 1'b0;
      cur_cols = cols;
      cur_rows = rows;
   endtask

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_COLS_IN_USE;
      csr_wdata         = 16'd0;
      req_valid         = 1'b0;
      req_opcode        = OP_NOP;
      req_col           = 8'd0;
      req_row           = 7'd0;
      req_byte0         = 8'd0;
      req_byte1         = 8'd0;
      req_byte2         = 8'd0;
      req_byte3         = 8'd0;
      req_byte_count    = 3'd0;
      req_attribute     = 16'd0;
      burst_left        = 0;
      cleared_since_cfg = 1'b0;
      cur_cols          = RST_COLS_IN_USE;
      cur_rows          = RST_ROWS_IN_USE;
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset geometry 80 x 25
      send_access(make_access(OP_READ, 8'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_WRITE, 8'd0, 7'd0, 8'h41, 8'hFF, 8'hFF, 8'hFF, 3'd1, 16'hFFFF));
      send_access(make_access(OP_READ, 8'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_WRITE, 8'd10, 7'd2, 8'hEA, 8'hB0, 8'h80, 8'h00, 3'd3, 16'h1234));
      send_access(make_access(OP_READ, 8'd10, 7'd2, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_READ, 8'd11, 7'd2, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      // wide char in the last column does not fit
      send_access(make_access(OP_WRITE, 8'd79, 7'd2, 8'hE9, 8'hBF, 8'hBF, 8'h00, 3'd3, 16'h0F0F));
      send_access(make_access(OP_WRITE, 8'd78, 7'd3, 8'hEF, 8'hA4, 8'h80, 8'h00, 3'd3, 16'h8001));
      send_access(make_access(OP_READ, 8'd79, 7'd3, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_WRITE, 8'd79, 7'd4, 8'h7A, 8'h00, 8'h00, 8'h00, 3'd1, 16'h00FF));
      send_access(make_access(OP_WRITE, 8'd80, 7'd4, 8'h7A, 8'h00, 8'h00, 8'h00, 3'd1, 16'h00FF));
      send_access(make_access(OP_WRITE, 8'd0, 7'd25, 8'h7A, 8'h00, 8'h00, 8'h00, 3'd1, 16'h00FF));
      send_access(make_access(OP_READ, 8'd255, 7'd127, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 16'hFFFF));
      send_access(make_access(OP_WRITE, 8'd3, 7'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 16'hAAAA));
      send_access(make_access(OP_READ, 8'd3, 7'd5, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_WRITE, 8'd4, 7'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 16'h5555));
      send_access(make_access(OP_READ, 8'd4, 7'd5, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_WRITE, 8'd5, 7'd5, 8'hF0, 8'h9F, 8'h98, 8'h80, 3'd4, 16'h0001));
      send_access(make_access(OP_READ, 8'd5, 7'd5, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_WRITE, 8'd6, 7'd5, 8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2, 16'h8000));
      send_access(make_access(OP_READ, 8'd6, 7'd5, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_NOP, 8'd0, 7'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd1, 16'hFFFF));
      send_access(make_access(OP_CLEAR, 8'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_READ, 8'd0, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      send_access(make_access(OP_READ, 8'd11, 7'd2, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 16'h0000));
      end_burst();

      for (int phase = 0; phase < 10; phase++) begin
         nattr = 16'($urandom);
         case (phase)
            0: begin ncols = 8'd128; nrows = 7'd64;  nattr = 16'hFFFF; end
            1: begin ncols = 8'd1;   nrows = 7'd1;   nattr = 16'h0000; end
            2: begin ncols = 8'd2;   nrows = 7'd1;   end
            3: begin ncols = 8'd24;  nrows = 7'd12;  end
            4: begin ncols = 8'd255; nrows = 7'd127; end
            5: begin ncols = 8'd0;   nrows = 7'd10;  end
            6: begin ncols = 8'd10;  nrows = 7'd0;   end
            7: begin ncols = 8'd129; nrows = 7'd65;  end
            8: begin ncols = 8'd7;   nrows = 7'd3;   end
            default: begin
               ncols = 8'($urandom_range(1, 40));
               nrows = 7'($urandom_range(1, 16));
            end
         endcase
         write_config(ncols, nrows, nattr);
         span_c = (cur_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cur_cols);
         span_r = (cur_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(cur_rows);
         clear_permille = (span_c * span_r <= 512) ? 25 : 3;
         repeat (75) send_access(random_access(span_c, span_r, clear_permille));
         end_burst();
      end

      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      rsp_ready     = 1'b0;
      rsp_mode      = 0;
      rsp_mode_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_mode_left == 0) begin
            rsp_mode      = $urandom_range(0, 3);
            rsp_mode_left = $urandom_range(16, 160);
         end
         rsp_mode_left--;
         case (rsp_mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            2: rsp_ready = (rsp_mode_left % 4 == 0);
            default: rsp_ready = ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got = {rsp_written_width, rsp_in_range, rsp_cell_byte3, rsp_cell_byte2,
                rsp_cell_byte1, rsp_cell_byte0, rsp_cell_count, rsp_cell_width,
                rsp_cell_attribute};
         sb.check_response(got);
      end
   end

   initial begin
      #30000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
